// File: rtl/core/display_overlap_screen_matcher_macros.svh
// Assertion helper macros for the screen matcher
`ifndef DISPLAY_OVERLAP_SCREEN_MATCHER_MACROS_SVH
`define DISPLAY_OVERLAP_SCREEN_MATCHER_MACROS_SVH
// implication checked every edge outside reset
`define DOSM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define DOSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/dosm_pkg.sv
// ----------------------------------------------------------------------------
// dosm_pkg
// Shared types and constants of the screen matcher.
// ----------------------------------------------------------------------------
package dosm_pkg;
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TO_GLOBAL = 2'd1;
  localparam logic [1:0] MODE_TO_LOCAL = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_RATIO_ZERO = 2'd2;
  localparam logic [1:0] ST_NO_OVERLAP = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DECIDE, S_SCAN, S_DIV, S_DIV_WAIT, S_AREA, S_MUL,
    S_CMP, S_FINISH, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // take input beat
    logic load;       // write table
    logic find_clr;   // reset search
    logic find_step;  // check entry at index
    logic scan_clr;   // reset scan index / best
    logic rd;         // read entry at scan index
    logic div_start;  // start both divisions
    logic div_step;
    logic area_calc;  // spans
    logic mul_calc;   // area product
    logic cmp;        // update best
    logic scan_next;
    logic finish;     // form result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic is_query;
    logic is_local;
    logic find_done;
    logic found;
    logic ratio_zero;
    logic used;
    logic div_done;
    logic scan_last;
  } stat_t;
endpackage

// File: rtl/core/dosm_ctrl.sv
// ----------------------------------------------------------------------------
// dosm_ctrl
// Sequencer for loads, lookups and the overlap scan.
// ----------------------------------------------------------------------------
module dosm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dosm_pkg::stat_t st,
  output dosm_pkg::cmd_t  cmd
);
  dosm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dosm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dosm_pkg::S_IDLE: if (in_valid) state_next = dosm_pkg::S_DECIDE;
      dosm_pkg::S_DECIDE: begin
        if (st.is_load || !st.is_query) state_next = dosm_pkg::S_IDLE;
        else state_next = dosm_pkg::S_FIND;
      end
      dosm_pkg::S_FIND: begin
        if (st.find_done) begin
          if (st.is_local && st.found && !st.ratio_zero) state_next = dosm_pkg::S_SCAN;
          else state_next = dosm_pkg::S_FINISH;
        end
      end
      dosm_pkg::S_SCAN: state_next = dosm_pkg::S_DIV;
      dosm_pkg::S_DIV: begin
        if (!st.used) state_next = st.scan_last ? dosm_pkg::S_FINISH : dosm_pkg::S_SCAN;
        else state_next = dosm_pkg::S_DIV_WAIT;
      end
      dosm_pkg::S_DIV_WAIT: if (st.div_done) state_next = dosm_pkg::S_AREA;
      dosm_pkg::S_AREA: state_next = dosm_pkg::S_MUL;
      dosm_pkg::S_MUL: state_next = dosm_pkg::S_CMP;
      dosm_pkg::S_CMP: state_next = st.scan_last ? dosm_pkg::S_FINISH : dosm_pkg::S_SCAN;
      dosm_pkg::S_FINISH: state_next = dosm_pkg::S_OUT;
      dosm_pkg::S_OUT: if (out_ready) state_next = dosm_pkg::S_IDLE;
      default: state_next = dosm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      dosm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      dosm_pkg::S_DECIDE: begin
        cmd.load = st.is_load;
        cmd.find_clr = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      dosm_pkg::S_FIND: cmd.find_step = 1'b1;
      dosm_pkg::S_SCAN: cmd.rd = 1'b1;
      dosm_pkg::S_DIV: begin
        cmd.div_start = st.used;
        cmd.scan_next = !st.used;
      end
      dosm_pkg::S_DIV_WAIT: cmd.div_step = 1'b1;
      dosm_pkg::S_AREA: cmd.area_calc = 1'b1;
      dosm_pkg::S_MUL: cmd.mul_calc = 1'b1;
      dosm_pkg::S_CMP: begin
        cmd.cmp = 1'b1;
        cmd.scan_next = 1'b1;
      end
      dosm_pkg::S_FINISH: cmd.finish = 1'b1;
      dosm_pkg::S_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// File: rtl/core/dosm_div.sv
// ----------------------------------------------------------------------------
// dosm_div
// Radix-2 restoring divider, one quotient bit per cycle while step is held.
// ----------------------------------------------------------------------------
module dosm_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   sh;

  assign sh = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NUM_W);
    end else if (step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      rem <= '0;
      d <= den;
    end else if (step && cnt != '0) begin
      if (sh >= {1'b0, d}) begin
        rem <= sh - {1'b0, d};
        q <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= sh;
        q <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = q;
  assign done = (cnt == '0);
endmodule

// File: rtl/core/dosm_dp.sv
// ----------------------------------------------------------------------------
// dosm_dp
// Screen table, lookup, scaled overlap scan and result registers.
// ----------------------------------------------------------------------------
module dosm_dp #(
  parameter int MAX_SCREENS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  dosm_pkg::cmd_t  cmd,
  output dosm_pkg::stat_t st,
  input  logic [15:0]     main_id,
  input  logic [1:0]      in_mode,
  input  logic [3:0]      in_slot,
  input  logic            in_entry_valid,
  input  logic [15:0]     in_screen_id,
  input  logic [15:0]     in_pos_x,
  input  logic [15:0]     in_pos_y,
  input  logic [14:0]     in_w,
  input  logic [14:0]     in_h,
  input  logic [15:0]     in_ratio,
  output logic [15:0]     matched_id,
  output logic [16:0]     out_x,
  output logic [16:0]     out_y,
  output logic [14:0]     out_w,
  output logic [14:0]     out_h,
  output logic [1:0]      status
);
  localparam int IW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
  localparam int NUM_W = 33;

  // captured beat
  logic [1:0]  mode;
  logic [3:0]  slot;
  logic        ev;
  logic [15:0] qid, ratio_in;
  logic signed [15:0] px, py;
  logic [14:0] w, h;

  // table: ids, origins, sizes in one memory, ratios in another; used bits in flops
  logic [MAX_SCREENS-1:0] used;
  logic [77:0] mem [MAX_SCREENS];
  logic [77:0] rd_q;

  // lookup / scan
  logic [IW:0]   fidx;
  logic          found;
  logic [15:0]   r0;
  logic signed [15:0] fox, foy;
  logic [IW:0]   sidx;
  logic          cur_used;
  logic          have_best;
  logic [15:0]   best_id;
  logic signed [15:0] best_ox, best_oy;
  logic [16:0]   spx, spy;

  logic [15:0] e_id;
  logic signed [15:0] e_ox, e_oy;
  logic [14:0] e_w, e_h;
  assign e_id = rd_q[15:0];
  assign e_ox = rd_q[31:16];
  assign e_oy = rd_q[47:32];
  assign e_w = rd_q[62:48];
  assign e_h = rd_q[77:63];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= in_mode; slot <= in_slot; ev <= in_entry_valid; qid <= in_screen_id;
      px <= in_pos_x; py <= in_pos_y; w <= in_w; h <= in_h; ratio_in <= in_ratio;
    end
  end

  logic [IW-1:0] rd_addr;
  logic [15:0]   ratio_mem [MAX_SCREENS];
  logic [15:0]   rd_ratio;
  assign rd_addr = cmd.find_step ? fidx[IW-1:0] : sidx[IW-1:0];

  logic slot_ok;
  logic [IW-1:0] slot_a;
  assign slot_ok = ({28'd0, slot} < 32'(MAX_SCREENS));
  assign slot_a = IW'(slot);

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok && ev) begin
      mem[slot_a] <= {h, w, py, px, qid};
      ratio_mem[slot_a] <= ratio_in;
    end
    rd_q <= mem[rd_addr];
    rd_ratio <= ratio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.load && slot_ok) begin
      used[slot_a] <= ev;
    end
  end

  // lookup: index presented in one cycle, checked the next
  logic fpend;
  logic [IW-1:0] fprev;
  always_ff @(posedge clk) begin
    if (cmd.find_clr) begin
      fidx <= '0; found <= 1'b0; fpend <= 1'b0;
    end else if (cmd.find_step) begin
      if (fidx != (IW+1)'(MAX_SCREENS)) fidx <= fidx + 1'b1;
      fpend <= (fidx != (IW+1)'(MAX_SCREENS));
      fprev <= fidx[IW-1:0];
      if (fpend && !found && used[fprev] && e_id == qid) begin
        found <= 1'b1; r0 <= rd_ratio; fox <= e_ox; foy <= e_oy;
      end
    end
  end
  assign st.find_done = (fidx == (IW+1)'(MAX_SCREENS)) && !fpend && cmd.find_step;

  // dividers: round(size*r/r0) = (2*size*r + r0) / (2*r0)
  logic [NUM_W-1:0] nw, nh, qw, qh;
  logic dw, dh;
  assign nw = NUM_W'({w, 1'b0}) * NUM_W'(rd_ratio) + NUM_W'(r0);
  assign nh = NUM_W'({h, 1'b0}) * NUM_W'(rd_ratio) + NUM_W'(r0);
  dosm_div #(.NUM_W(NUM_W), .DEN_W(17)) u_divw (.clk, .rst, .start(cmd.div_start),
    .step(cmd.div_step), .num(nw), .den({r0, 1'b0}), .quo(qw), .done(dw));
  dosm_div #(.NUM_W(NUM_W), .DEN_W(17)) u_divh (.clk, .rst, .start(cmd.div_start),
    .step(cmd.div_step), .num(nh), .den({r0, 1'b0}), .quo(qh), .done(dh));

  logic [15:0] sw, sh;
  assign sw = (qw > 33'd65535) ? 16'hFFFF : qw[15:0];
  assign sh = (qh > 33'd65535) ? 16'hFFFF : qh[15:0];

  function automatic logic [16:0] span_f(input logic signed [15:0] a0, input logic [15:0] al,
                                         input logic signed [15:0] b0, input logic [14:0] bl);
    logic signed [18:0] lo, hi, ae, be;
    begin
      ae = 19'(a0) + $signed({3'd0, al});
      be = 19'(b0) + $signed({4'd0, bl});
      lo = (a0 > b0) ? 19'(a0) : 19'(b0);
      hi = (ae < be) ? ae : be;
      span_f = (hi > lo) ? 17'(hi - lo) : 17'd0;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.area_calc) begin
      spx <= span_f(px, sw, e_ox, e_w);
      spy <= span_f(py, sh, e_oy, e_h);
    end
  end

  // spans fit in 17 bits, so the area fits in 34
  logic [33:0] area_full, best_full;
  always_ff @(posedge clk) begin
    if (cmd.mul_calc) area_full <= 34'(spx) * 34'(spy);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      sidx <= '0; have_best <= 1'b0; best_full <= '0;
    end else begin
      if (cmd.scan_next) sidx <= sidx + 1'b1;
      if (cmd.cmp && area_full != '0 && (area_full > best_full ||
          (area_full == best_full && e_id < best_id))) begin
        have_best <= 1'b1; best_full <= area_full; best_id <= e_id;
        best_ox <= e_ox; best_oy <= e_oy;
      end
    end
  end

  assign st.is_load = (mode == dosm_pkg::MODE_LOAD);
  assign st.is_query = (mode == dosm_pkg::MODE_TO_GLOBAL) || (mode == dosm_pkg::MODE_TO_LOCAL);
  assign st.is_local = (mode == dosm_pkg::MODE_TO_LOCAL);
  assign st.found = found;
  assign st.ratio_zero = (r0 == 16'd0);
  assign cur_used = used[sidx[IW-1:0]];
  assign st.used = cur_used;
  assign st.div_done = dw && dh;
  assign st.scan_last = (sidx == (IW+1)'(MAX_SCREENS - 1));

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_w <= w; out_h <= h;
      matched_id <= qid; out_x <= 17'(px); out_y <= 17'(py); status <= dosm_pkg::ST_OK;
      if (!st.is_local) begin
        if (found) begin
          out_x <= 17'(fox) + 17'(px); out_y <= 17'(foy) + 17'(py);
        end else begin
          status <= dosm_pkg::ST_MISSING;
        end
      end else if (!found) begin
        matched_id <= main_id; status <= dosm_pkg::ST_MISSING;
      end else if (r0 == 16'd0) begin
        matched_id <= main_id; status <= dosm_pkg::ST_RATIO_ZERO;
      end else if (have_best) begin
        matched_id <= best_id;
        out_x <= 17'(px) - 17'(best_ox); out_y <= 17'(py) - 17'(best_oy);
      end else begin
        status <= dosm_pkg::ST_NO_OVERLAP;
        out_x <= 17'(px) - 17'(fox); out_y <= 17'(py) - 17'(foy);
      end
    end
  end
endmodule

// File: rtl/core/display_overlap_screen_matcher.sv
// A load is captured and then written in the decode state. A query passes decode,
// the table lookup and the result register before its result is valid; a mode 2
// query whose screen is found with a nonzero ratio adds a scan of every slot,
// with a divider wait for each used slot. One item is in work at a time; the next beat is
// accepted the cycle after the result beat. Reset is synchronous, active high;
// it clears the used bits, main_screen_id and the controller; table contents persist.
// ----------------------------------------------------------------------------
// display_overlap_screen_matcher
// Screen table with coordinate conversion and best-overlap screen search.
// ----------------------------------------------------------------------------
module display_overlap_screen_matcher #(
  parameter int MAX_SCREENS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], slot[5:2], entry_valid[6], screen_id[22:7], pos_x[38:23],
  // pos_y[54:39], rect_width[69:55], rect_height[84:70], pixel_ratio[100:85]
  input  logic [103:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // matched_id[15:0], out_x[32:16], out_y[49:33], out_width[64:50],
  // out_height[79:65], status[81:80]
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  dosm_pkg::cmd_t  cmd;
  dosm_pkg::stat_t st;
  logic [15:0] main_screen_id;
  logic [15:0] mid;
  logic [16:0] ox, oy;
  logic [14:0] ow, oh;
  logic [1:0]  ost;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      main_screen_id <= '0;
    end else if (cfg_valid) begin
      main_screen_id <= cfg_data;
    end
  end

  dosm_ctrl u_ctrl (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .st, .cmd);

  dosm_dp #(.MAX_SCREENS(MAX_SCREENS)) u_dp (.clk, .rst, .cmd, .st,
    .main_id(main_screen_id), .in_mode(s_tdata[1:0]), .in_slot(s_tdata[5:2]),
    .in_entry_valid(s_tdata[6]), .in_screen_id(s_tdata[22:7]),
    .in_pos_x(s_tdata[38:23]), .in_pos_y(s_tdata[54:39]), .in_w(s_tdata[69:55]),
    .in_h(s_tdata[84:70]), .in_ratio(s_tdata[100:85]), .matched_id(mid),
    .out_x(ox), .out_y(oy), .out_w(ow), .out_h(oh), .status(ost));

  assign m_tdata = {6'd0, ost, oh, ow, oy, ox, mid};
endmodule

// File: rtl/core/dosm_checker.sv
// ----------------------------------------------------------------------------
// dosm_checker
// Port-level checks for the screen matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "display_overlap_screen_matcher_macros.svh"
module dosm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);
  `DOSM_ASSERT_IMP(no_accept_while_out, clk, rst, m_tvalid, !s_tready)
  `DOSM_ASSERT_NEXT(busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `DOSM_ASSERT_NEXT(out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `DOSM_ASSERT_IMP(pad_zero, clk, rst, m_tvalid, m_tdata[87:82] == 6'd0)
endmodule

bind display_overlap_screen_matcher dosm_checker u_chk (.clk, .rst, .s_tvalid, .s_tready,
  .m_tvalid, .m_tready, .m_tdata);

// File: test/display_overlap_screen_matcher_tb.sv
// ----------------------------------------------------------------------------
// display_overlap_screen_matcher_tb
// Drives loads, queries and noise items into the screen matcher, predicts
// each query answer from a private copy of the screen table and checks every
// output beat against the oldest pending answer. Both sides idle at random.
// ----------------------------------------------------------------------------
module display_overlap_screen_matcher_tb;
  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 700;
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    logic [3:0]         slot;
    logic               entry_valid;
    logic [15:0]        screen_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [15:0]        pixel_ratio;
  } screen_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [14:0]        out_height;
    logic [14:0]        out_width;
    logic signed [16:0] out_y;
    logic signed [16:0] out_x;
    logic [15:0]        matched_id;
  } placement_t;

  int mismatches = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  class placement_scoreboard;
    bit           used[NSLOT];
    logic [15:0]  ident[NSLOT];
    int           org_x[NSLOT];
    int           org_y[NSLOT];
    longint       ext_w[NSLOT];
    longint       ext_h[NSLOT];
    longint       ratio[NSLOT];
    logic [15:0]  main_id;
    placement_t   pending[$];

    function new();
      foreach (used[i]) used[i] = 0;
      main_id = '0;
    endfunction

    function automatic longint scaled(longint size, longint r, longint r0);
      longint q;
      q = (2 * size * r + r0) / (2 * r0);
      return (q > 65535) ? 65535 : q;
    endfunction

    function automatic longint span(longint a0, longint al, longint b0, longint bl);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
      return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic int lookup(logic [15:0] id);
      for (int s = 0; s < NSLOT; s++)
        if (used[s] && ident[s] == id) return s;
      return -1;
    endfunction

    function automatic void note_input(screen_item_t it);
      placement_t p;
      int s, best;
      longint area, best_area, r0, sw, sh, ox, oy;
      if (it.mode == dosm_pkg::MODE_LOAD) begin
        if (it.entry_valid) begin
          used[it.slot] = 1;
          ident[it.slot] = it.screen_id;
          org_x[it.slot] = it.pos_x;
          org_y[it.slot] = it.pos_y;
          ext_w[it.slot] = it.rect_width;
          ext_h[it.slot] = it.rect_height;
          ratio[it.slot] = it.pixel_ratio;
        end else begin
          used[it.slot] = 0;
        end
        return;
      end
      if (it.mode == MODE_NOP) return;
      s = lookup(it.screen_id);
      p.matched_id = it.screen_id;
      p.status = dosm_pkg::ST_OK;
      ox = it.pos_x;
      oy = it.pos_y;
      if (it.mode == dosm_pkg::MODE_TO_GLOBAL) begin
        if (s < 0) p.status = dosm_pkg::ST_MISSING;
        else begin
          ox = org_x[s] + it.pos_x;
          oy = org_y[s] + it.pos_y;
        end
      end else if (s < 0) begin
        p.matched_id = main_id;
        p.status = dosm_pkg::ST_MISSING;
      end else if (ratio[s] == 0) begin
        p.matched_id = main_id;
        p.status = dosm_pkg::ST_RATIO_ZERO;
      end else begin
        r0 = ratio[s];
        best = -1;
        best_area = 0;
        for (int k = 0; k < NSLOT; k++) begin
          if (!used[k]) continue;
          sw = scaled(it.rect_width, ratio[k], r0);
          sh = scaled(it.rect_height, ratio[k], r0);
          area = span(it.pos_x, sw, org_x[k], ext_w[k]) *
                 span(it.pos_y, sh, org_y[k], ext_h[k]);
          if (area > best_area ||
              (area != 0 && area == best_area && ident[k] < ident[best])) begin
            best_area = area;
            best = k;
          end
        end
        if (best < 0) begin
          best = s;
          p.status = dosm_pkg::ST_NO_OVERLAP;
        end
        p.matched_id = ident[best];
        ox = it.pos_x - org_x[best];
        oy = it.pos_y - org_y[best];
      end
      p.out_x = ox[16:0];
      p.out_y = oy[16:0];
      p.out_width = it.rect_width;
      p.out_height = it.rect_height;
      pending.push_back(p);
    endfunction

    task automatic check_result(placement_t got);
      placement_t want;
      if (pending.size() == 0) begin
        report("unexpected beat, matched_id", got.matched_id, -1);
        return;
      end
      want = pending.pop_front();
      if (got.matched_id !== want.matched_id)
        report("matched_id", got.matched_id, want.matched_id);
      if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
      if (got.out_width !== want.out_width)
        report("out_width", got.out_width, want.out_width);
      if (got.out_height !== want.out_height)
        report("out_height", got.out_height, want.out_height);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [87:0]  m_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  placement_scoreboard board = new();
  int  cycles = 0;
  int  accepted = 0;
  logic hold_out = 0;
  bit  quiet = 0;  // no idling on either side while set
  int  stall_left = 0;
  logic [15:0] id_pool[8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd100,
                              16'd32768, 16'd65535};

  display_overlap_screen_matcher #(.MAX_SCREENS(NSLOT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("display_overlap_screen_matcher regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst || hold_out) m_tready <= 0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 0;
    end else begin
      stall_left <= gap_len();
      m_tready <= 1;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata[81:0]);

  // long output hold-off while the sender keeps offering
  initial begin
    wait (accepted == 60);
    @(posedge clk) hold_out <= 1;
    repeat (3000) @(posedge clk);
    hold_out <= 0;
  end

  function automatic logic [103:0] pack_item(screen_item_t it);
    return {3'b0, it.pixel_ratio, it.rect_height, it.rect_width, it.pos_y, it.pos_x,
            it.screen_id, it.entry_valid, it.slot, it.mode};
  endfunction

  task automatic send(screen_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_item(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(it);
    accepted++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_main_id(logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.main_id = v;
    cfg_valid <= 0;
  endtask

  task automatic load(int slot, logic [15:0] id, int x, int y, int w, int h,
                      logic [15:0] r, bit keep = 1);
    screen_item_t it;
    it = '{dosm_pkg::MODE_LOAD, slot[3:0], keep, id, x[15:0], y[15:0], w[14:0], h[14:0], r};
    send(it);
  endtask

  task automatic query(logic [1:0] m, logic [15:0] id, int x, int y, int w, int h);
    screen_item_t it;
    it = '{m, 4'($urandom), 1'($urandom), id, x[15:0], y[15:0], w[14:0], h[14:0],
           16'($urandom)};
    send(it);
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
  endfunction

  function automatic int pick_pos();
    return ($urandom_range(0, 4) == 0) ? int'(16'($urandom)) - 32768
                                       : $urandom_range(0, 4000) - 1000;
  endfunction

  task automatic random_items(int n);
    screen_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      it.mode = (r < 35) ? dosm_pkg::MODE_LOAD : (r < 55) ? dosm_pkg::MODE_TO_GLOBAL :
                (r < 95) ? dosm_pkg::MODE_TO_LOCAL : MODE_NOP;
      it.slot = 4'($urandom);
      it.entry_valid = ($urandom_range(0, 5) != 0);
      it.screen_id = pick_id();
      it.pos_x = 16'(pick_pos());
      it.pos_y = 16'(pick_pos());
      it.rect_width = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2500));
      it.rect_height = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2500));
      r = $urandom_range(0, 9);
      it.pixel_ratio = (r < 5) ? 16'(1024 * $urandom_range(1, 8)) :
                       (r < 9) ? 16'($urandom) : 16'd0;
      send(it);
      if (i % 80 == 40) quiet = ~quiet;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    write_main_id(16'hFFFF);
    // directed: a desktop of screens
    load(0, 16'd1, 0, 0, 1920, 1080, 16'd4096);
    load(1, 16'd2, 1920, 0, 1280, 1024, 16'd8192);
    load(2, 16'd65535, -32768, -32768, 32767, 32767, 16'd65535);
    load(3, 16'd3, 5000, 5000, 100, 100, 16'd0);
    load(5, 16'd4, 0, 0, 10, 10, 16'd1);
    load(6, 16'd2, 1920, 0, 1280, 1024, 16'd8192);  // duplicate id, higher slot
    query(dosm_pkg::MODE_TO_GLOBAL, 16'd2, 100, 200, 50, 60);
    query(dosm_pkg::MODE_TO_GLOBAL, 16'd9, 32767, -32768, 32767, 32767);  // missing screen
    query(dosm_pkg::MODE_TO_LOCAL, 16'd1, 1800, 100, 400, 300);           // spans two screens
    query(dosm_pkg::MODE_TO_LOCAL, 16'd1, 1910, 0, 20, 20);               // equal area tie
    query(dosm_pkg::MODE_TO_LOCAL, 16'd9, 10, 10, 5, 5);                  // original missing
    query(dosm_pkg::MODE_TO_LOCAL, 16'd3, 10, 10, 5, 5);                  // ratio zero
    query(dosm_pkg::MODE_TO_LOCAL, 16'd1, 30000, 30000, 10, 10);          // no overlap
    query(dosm_pkg::MODE_TO_LOCAL, 16'd4, -100, -100, 32767, 32767);      // saturated sizes
    query(dosm_pkg::MODE_TO_LOCAL, 16'd65535, 32767, 32767, 0, 0);        // zero size
    query(MODE_NOP, 16'd1, 1, 1, 1, 1);
    load(1, 16'd2, 0, 0, 0, 0, 16'd0, 0);                                 // remove an entry
    query(dosm_pkg::MODE_TO_GLOBAL, 16'd2, -32768, 32767, 1, 1);
    load(15, 16'd7, -2000, 300, 32767, 0, 16'd4096);
    query(dosm_pkg::MODE_TO_LOCAL, 16'd7, -1000, 300, 10, 10);
    random_items(230);
    drain();
    write_main_id(16'h0000);
    random_items(230);
    drain();
    write_main_id(16'($urandom));
    random_items(230);
    drain();
    if (mismatches == 0) $display("display_overlap_screen_matcher regression: pass");
    else $display("display_overlap_screen_matcher regression: fail");
    $finish;
  end
endmodule
